@@ src/prq_pkg.sv @@
// shared types and constants of the priority ready queue scheduler
`default_nettype none

package prq_pkg;

    // fixed field widths of the request and result
    localparam int TASK_W  = 6;
    localparam int LEVEL_W = 5;
    localparam int COUNT_W = 7;

    // ready counter saturation limit
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // one entry of the per-level head/tail table
    typedef struct packed {
        logic [TASK_W-1:0] head;
        logic [TASK_W-1:0] tail;
    } t_ht_entry;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_LINK = 3'b100
    } t_state;

endpackage

`default_nettype wire

@@ src/prq_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/prq_ffs.sv @@
// find-first-set over the non-empty level mask, lowest level wins
`default_nettype none

module prq_ffs #(
    parameter int NUM_LEVELS = 32
) (
    input  wire logic [NUM_LEVELS-1:0]         i_mask,
    output logic                               o_found,
    output logic [$clog2(NUM_LEVELS)-1:0]      o_index
);

    localparam int LW = $clog2(NUM_LEVELS);

    // scan from the top so the lowest set bit is kept last
    always_comb begin
        o_index = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                o_index = LW'(i);
            end
        end
    end

    assign o_found = |i_mask;

endmodule

`default_nettype wire

@@ src/priority_ready_queue_scheduler.sv @@
// top level of the bitmap multilevel priority ready queue scheduler
//
//  channel   | direction | handshake               | fields
//  ----------+-----------+-------------------------+------------------------------------------
//  request   | in        | start high, busy low    | i_operation, i_task_number, i_task_level
//  result    | out       | o_done, one cycle       | o_chosen_task, o_chosen_level,
//            |           |                         | o_empty_error, o_ready_total
//
//  enqueue: 2 cycles (head/tail table read, then write of table and link)
//  dequeue: 2 cycles when the level holds one task, 3 when the next link must be
//  read from the link table before the head can be updated
//  dequeue on empty or enqueue out of range: 1 cycle, no table access
//  reset is synchronous and active low; tables hold no reset, only mask and counter
//  results cannot be stalled; one request at a time, busy high while tables update
`default_nettype none

module priority_ready_queue_scheduler
    import prq_pkg::*;
#(
    parameter int NUM_LEVELS = 32,
    parameter int NUM_TASKS  = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_operation,
    input  wire logic [TASK_W-1:0]  i_task_number,
    input  wire logic [LEVEL_W-1:0] i_task_level,
    output logic                    o_done,
    output logic [TASK_W-1:0]       o_chosen_task,
    output logic [LEVEL_W-1:0]      o_chosen_level,
    output logic                    o_empty_error,
    output logic [COUNT_W-1:0]      o_ready_total
);

    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(NUM_TASKS);

    // control and request registers
    t_state                 r_state, n_state;
    logic [NUM_LEVELS-1:0]  r_mask, n_mask;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_op, n_op;
    logic [TASK_W-1:0]      r_task, n_task;
    logic [LW-1:0]          r_level, n_level;
    logic                   r_nonempty, n_nonempty;
    logic [TASK_W-1:0]      r_head, n_head;
    logic [TASK_W-1:0]      r_tail, n_tail;

    // result registers
    logic                   r_done, n_done;
    logic [TASK_W-1:0]      r_chosen_task, n_chosen_task;
    logic [LEVEL_W-1:0]     r_chosen_level, n_chosen_level;
    logic                   r_empty_error, n_empty_error;

    // memory ports
    logic                   ht_we;
    logic [LW-1:0]          ht_waddr, ht_raddr;
    t_ht_entry              ht_wdata, ht_rdata;
    logic                   lk_we;
    logic [TW-1:0]          lk_waddr, lk_raddr;
    logic [TASK_W-1:0]      lk_wdata, lk_rdata;

    logic                   ffs_found;
    logic [LW-1:0]          ffs_index;
    logic                   accept;
    logic                   req_in_range;
    logic [COUNT_W-1:0]     count_inc, count_dec;

    // head/tail table, one entry per level
    prq_ram #(
        .WIDTH ($bits(t_ht_entry)),
        .DEPTH (NUM_LEVELS)
    ) u_ht_ram (
        .i_clk   (i_clk),
        .i_we    (ht_we),
        .i_waddr (ht_waddr),
        .i_wdata (ht_wdata),
        .i_raddr (ht_raddr),
        .o_rdata (ht_rdata)
    );

    // next-link table, one entry per task
    prq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (NUM_TASKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    // most urgent non-empty level
    prq_ffs #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_ffs (
        .i_mask  (r_mask),
        .o_found (ffs_found),
        .o_index (ffs_index)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign req_in_range = (32'(i_task_number) < NUM_TASKS) &&
                          (32'(i_task_level) < NUM_LEVELS);

    // saturating counter steps
    assign count_inc = (r_count != COUNT_MAX) ? COUNT_W'(r_count + 1'b1) : r_count;
    assign count_dec = (r_count != '0) ? COUNT_W'(r_count - 1'b1) : r_count;

    // read addresses: level on accept, head task for the link lookup
    assign ht_raddr = (i_operation == OP_DEQUEUE) ? ffs_index : LW'(i_task_level);
    assign lk_raddr = TW'(ht_rdata.head);

    // sequencer: read, modify, write back
    always_comb begin
        n_state        = r_state;
        n_mask         = r_mask;
        n_count        = r_count;
        n_op           = r_op;
        n_task         = r_task;
        n_level        = r_level;
        n_nonempty     = r_nonempty;
        n_head         = r_head;
        n_tail         = r_tail;
        n_done         = 1'b0;
        n_chosen_task  = r_chosen_task;
        n_chosen_level = r_chosen_level;
        n_empty_error  = r_empty_error;
        ht_we          = 1'b0;
        ht_waddr       = r_level;
        ht_wdata       = '{head: r_task, tail: r_task};
        lk_we          = 1'b0;
        lk_waddr       = TW'(ht_rdata.tail);
        lk_wdata       = r_task;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op   = i_operation;
                    n_task = i_task_number;
                    if (i_operation == OP_DEQUEUE) begin
                        n_level = ffs_index;
                        if (!ffs_found) begin
                            // dequeue on empty: flag only
                            n_done         = 1'b1;
                            n_chosen_task  = '0;
                            n_chosen_level = '0;
                            n_empty_error  = 1'b1;
                        end else begin
                            n_state = S_UPD;
                        end
                    end else begin
                        n_level    = LW'(i_task_level);
                        n_nonempty = r_mask[LW'(i_task_level)];
                        if (!req_in_range) begin
                            // ignored enqueue
                            n_done         = 1'b1;
                            n_chosen_task  = '0;
                            n_chosen_level = '0;
                            n_empty_error  = 1'b0;
                        end else begin
                            n_state = S_UPD;
                        end
                    end
                end
            end

            S_UPD: begin
                if (r_op == OP_ENQUEUE) begin
                    // append at tail, link from old tail when level was busy
                    ht_we = 1'b1;
                    if (r_nonempty) begin
                        ht_wdata = '{head: ht_rdata.head, tail: r_task};
                        lk_we    = 1'b1;
                    end
                    n_mask[r_level] = 1'b1;
                    n_count         = count_inc;
                    n_done          = 1'b1;
                    n_chosen_task   = '0;
                    n_chosen_level  = '0;
                    n_empty_error   = 1'b0;
                    n_state         = S_IDLE;
                end else begin
                    n_head = ht_rdata.head;
                    n_tail = ht_rdata.tail;
                    if (ht_rdata.head == ht_rdata.tail) begin
                        // last task of the level
                        n_mask[r_level] = 1'b0;
                        n_count         = count_dec;
                        n_done          = 1'b1;
                        n_chosen_task   = ht_rdata.head;
                        n_chosen_level  = LEVEL_W'(r_level);
                        n_empty_error   = 1'b0;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_LINK;
                    end
                end
            end

            S_LINK: begin
                // advance head to the linked task
                ht_we          = 1'b1;
                ht_wdata       = '{head: lk_rdata, tail: r_tail};
                n_count        = count_dec;
                n_done         = 1'b1;
                n_chosen_task  = r_head;
                n_chosen_level = LEVEL_W'(r_level);
                n_empty_error  = 1'b0;
                n_state        = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mask  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op           <= n_op;
        r_task         <= n_task;
        r_level        <= n_level;
        r_nonempty     <= n_nonempty;
        r_head         <= n_head;
        r_tail         <= n_tail;
        r_chosen_task  <= n_chosen_task;
        r_chosen_level <= n_chosen_level;
        r_empty_error  <= n_empty_error;
    end

    // result ports
    assign o_done         = r_done;
    assign o_chosen_task  = r_chosen_task;
    assign o_chosen_level = r_chosen_level;
    assign o_empty_error  = r_empty_error;
    assign o_ready_total  = r_count;

    // a result never shows while tables are still being updated
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // every accepted request either starts table work or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("accepted request made no progress");

    // the link step always finishes the dequeue
    a_link_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (o_done && !busy))
        else $error("link step did not complete the dequeue");

    // an error result never carries a popped task
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_empty_error) |-> (o_chosen_task == '0 && o_chosen_level == '0))
        else $error("error result with task payload");

endmodule

`default_nettype wire

@@ tb/priority_ready_queue_scheduler_checker.sv @@
// checker that predicts and compares scheduler results against accepted requests
module priority_ready_queue_scheduler_checker
    import prq_pkg::*;
#(
    parameter int NUM_LEVELS = 32,
    parameter int NUM_TASKS  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_operation,
    input  logic [TASK_W-1:0]  i_task_number,
    input  logic [LEVEL_W-1:0] i_task_level,
    input  logic               i_done,
    input  logic [TASK_W-1:0]  i_chosen_task,
    input  logic [LEVEL_W-1:0] i_chosen_level,
    input  logic               i_empty_error,
    input  logic [COUNT_W-1:0] i_ready_total,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TASK_W-1:0]  chosen_task;
        logic [LEVEL_W-1:0] chosen_level;
        logic               empty_error;
        logic [COUNT_W-1:0] ready_total;
    } t_sched_result;

    // shadow copy of the scheduler state
    logic [TASK_W-1:0]     shadow_head [NUM_LEVELS];
    logic [TASK_W-1:0]     shadow_tail [NUM_LEVELS];
    logic [TASK_W-1:0]     shadow_link [NUM_TASKS];
    logic [NUM_LEVELS-1:0] shadow_mask;
    logic [COUNT_W-1:0]    shadow_count;

    t_sched_result expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        shadow_mask  = '0;
        shadow_count = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            shadow_head[i] = '0;
            shadow_tail[i] = '0;
        end
        for (int i = 0; i < NUM_TASKS; i++) begin
            shadow_link[i] = '0;
        end
    end

    // apply one request to the shadow state and return what the block must report
    function automatic t_sched_result predict_schedule_step(
        input logic               op,
        input logic [TASK_W-1:0]  tnum,
        input logic [LEVEL_W-1:0] tlvl
    );
        t_sched_result res;
        int            lvl;
        logic [TASK_W-1:0] head_task;
        res = '0;
        if (op == OP_ENQUEUE) begin
            // append at the tail of the level; out-of-range requests are ignored
            if (int'(tnum) < NUM_TASKS && int'(tlvl) < NUM_LEVELS) begin
                if (!shadow_mask[tlvl]) begin
                    shadow_head[tlvl] = tnum;
                    shadow_mask[tlvl] = 1'b1;
                end else if (int'(shadow_tail[tlvl]) < NUM_TASKS) begin
                    shadow_link[shadow_tail[tlvl]] = tnum;
                end
                shadow_tail[tlvl] = tnum;
                if (shadow_count != COUNT_MAX) shadow_count = shadow_count + 1'b1;
            end
        end else if (shadow_mask == '0) begin
            // dequeue with nothing ready
            res.empty_error = 1'b1;
        end else begin
            // find-first-set over the level bitmap, then pop that level's head
            lvl = 0;
            for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
                if (shadow_mask[l]) lvl = l;
            end
            head_task = shadow_head[lvl];
            if (shadow_tail[lvl] == head_task) begin
                shadow_mask[lvl] = 1'b0;
            end else begin
                shadow_head[lvl] = shadow_link[head_task];
            end
            res.chosen_task  = head_task;
            res.chosen_level = LEVEL_W'(lvl);
            if (shadow_count != '0) shadow_count = shadow_count - 1'b1;
        end
        res.ready_total = shadow_count;
        return res;
    endfunction

    task automatic report_mismatch(
        input string         what,
        input t_sched_result want,
        input t_sched_result seen
    );
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t mismatch (%s): expected task %0d level %0d err %0b total %0d",
                     $realtime, what, want.chosen_task, want.chosen_level,
                     want.empty_error, want.ready_total);
            $display("%0t                 actual   task %0d level %0d err %0b total %0d",
                     $realtime, seen.chosen_task, seen.chosen_level,
                     seen.empty_error, seen.ready_total);
        end
    endtask

    // results are matched before a request at the same edge is predicted
    always @(posedge i_clk) begin : check_results
        t_sched_result seen;
        t_sched_result want;
        if (!i_rst_n) begin
            shadow_mask  = '0;
            shadow_count = '0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                seen = '{i_chosen_task, i_chosen_level, i_empty_error, i_ready_total};
                if (expected_results.size() == 0) begin
                    report_mismatch("no request outstanding", '0, seen);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.chosen_task !== want.chosen_task) begin
                        report_mismatch("chosen task", want, seen);
                    end else if (seen.chosen_level !== want.chosen_level) begin
                        report_mismatch("chosen level", want, seen);
                    end else if (seen.empty_error !== want.empty_error) begin
                        report_mismatch("empty error", want, seen);
                    end else if (seen.ready_total !== want.ready_total) begin
                        report_mismatch("ready total", want, seen);
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(
                    predict_schedule_step(i_operation, i_task_number, i_task_level));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/priority_ready_queue_scheduler_tb.sv @@
// testbench top of the priority ready queue scheduler: stimulus, watchdog and verdict
module priority_ready_queue_scheduler_tb
    import prq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS    = 32;
    localparam int NUM_TASKS     = 64;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int CALM_ITEMS    = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [TASK_W-1:0]  i_task_number;
    logic [LEVEL_W-1:0] i_task_level;
    logic               o_done;
    logic [TASK_W-1:0]  o_chosen_task;
    logic [LEVEL_W-1:0] o_chosen_level;
    logic               o_empty_error;
    logic [COUNT_W-1:0] o_ready_total;

    int fail_count;
    int pending_results;
    int stall_cycles;

    // tasks that may still sit in the queues, so none is queued twice
    logic [NUM_TASKS-1:0] queued_tasks;
    logic                 issued_ops[$];

    priority_ready_queue_scheduler #(
        .NUM_LEVELS(NUM_LEVELS),
        .NUM_TASKS (NUM_TASKS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_task_number (i_task_number),
        .i_task_level  (i_task_level),
        .o_done        (o_done),
        .o_chosen_task (o_chosen_task),
        .o_chosen_level(o_chosen_level),
        .o_empty_error (o_empty_error),
        .o_ready_total (o_ready_total)
    );

    priority_ready_queue_scheduler_checker #(
        .NUM_LEVELS(NUM_LEVELS),
        .NUM_TASKS (NUM_TASKS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_operation   (i_operation),
        .i_task_number (i_task_number),
        .i_task_level  (i_task_level),
        .i_done        (o_done),
        .i_chosen_task (o_chosen_task),
        .i_chosen_level(o_chosen_level),
        .i_empty_error (o_empty_error),
        .i_ready_total (o_ready_total),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // occupancy bookkeeping: a task is freed only once its dequeue result is back
    always @(posedge i_clk) begin : track_queued
        logic op;
        if (!i_rst_n) begin
            queued_tasks = '0;
            issued_ops.delete();
        end else begin
            if (o_done && issued_ops.size() > 0) begin
                op = issued_ops.pop_front();
                if (op == OP_DEQUEUE && !o_empty_error) queued_tasks[o_chosen_task] = 1'b0;
            end
            if (start && !busy) begin
                issued_ops.push_back(i_operation);
                if (i_operation == OP_ENQUEUE) queued_tasks[i_task_number] = 1'b1;
            end
        end
    end

    // watchdog on cycles with neither a request nor a result accepted
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one request, optionally after an idle burst, and wait until it is taken
    task automatic issue_request(
        input logic               op,
        input logic [TASK_W-1:0]  tnum,
        input logic [LEVEL_W-1:0] tlvl,
        input int                 gap
    );
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_operation   <= op;
        i_task_number <= tnum;
        i_task_level  <= tlvl;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
    endtask

    initial begin
        int                 occupancy;
        int                 fill_target;
        int                 level_lo;
        int                 level_hi;
        int                 gap;
        int                 first_try;
        int                 idx;
        bit                 filling;
        bit                 gaps_on;
        bit                 do_enqueue;
        logic [TASK_W-1:0]  tnum;
        logic [LEVEL_W-1:0] tlvl;

        stall_cycles  = 0;
        queued_tasks  = '0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_operation   = OP_ENQUEUE;
        i_task_number = '0;
        i_task_level  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty dequeue, field extremes, fifo order inside a level, drain to empty
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_ENQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_ENQUEUE, 6'd63, 5'd31, 0);
        issue_request(OP_ENQUEUE, 6'd42, 5'd21, 3);
        issue_request(OP_ENQUEUE, 6'd21, 5'd10, 0);
        issue_request(OP_ENQUEUE, 6'd5, 5'd31, 0);
        issue_request(OP_ENQUEUE, 6'd58, 5'd31, 1);
        issue_request(OP_DEQUEUE, 6'd63, 5'd31, 0);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 2);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_ENQUEUE, 6'd0, 5'd31, 0);
        issue_request(OP_ENQUEUE, 6'd63, 5'd0, 0);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 5);
        issue_request(OP_DEQUEUE, 6'd0, 5'd0, 0);
        issue_request(OP_DEQUEUE, 6'd63, 5'd31, 0);

        // random: fill and drain episodes, each with its own spread of levels
        filling     = 1'b0;
        gaps_on     = 1'b0;
        fill_target = 1;
        level_lo    = 0;
        level_hi    = NUM_LEVELS - 1;
        for (int item = 0; item < RANDOM_ITEMS; item++) begin
            if (item % 40 == 0) begin
                gaps_on = (item < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 2) != 0);
            end
            occupancy = $countones(queued_tasks);
            if (filling && occupancy >= fill_target) filling = 1'b0;
            if (!filling && occupancy == 0) begin
                filling     = 1'b1;
                fill_target = $urandom_range(1, NUM_TASKS);
                case ($urandom_range(0, 2))
                    0: begin
                        level_lo = 0;
                        level_hi = NUM_LEVELS - 1;
                    end
                    1: begin
                        level_lo = $urandom_range(0, NUM_LEVELS - 1);
                        level_hi = level_lo;
                    end
                    default: begin
                        level_lo = $urandom_range(0, NUM_LEVELS - 4);
                        level_hi = level_lo + 3;
                    end
                endcase
            end
            do_enqueue = filling ? ($urandom_range(0, 99) < 75) : ($urandom_range(0, 99) < 25);
            if (occupancy == NUM_TASKS) do_enqueue = 1'b0;

            tnum = TASK_W'($urandom);
            tlvl = LEVEL_W'($urandom);
            if (do_enqueue) begin
                // pick a free task starting from a random point
                first_try = $urandom_range(0, NUM_TASKS - 1);
                for (int k = NUM_TASKS - 1; k >= 0; k--) begin
                    idx = (first_try + k) % NUM_TASKS;
                    if (!queued_tasks[idx]) tnum = TASK_W'(idx);
                end
                tlvl = LEVEL_W'($urandom_range(level_lo, level_hi));
            end

            gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
            issue_request(do_enqueue ? OP_ENQUEUE : OP_DEQUEUE, tnum, tlvl, gap);
        end
        start <= 1'b0;

        // let every outstanding result come back, then settle
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/prq_pkg.sv
src/prq_ram.sv
src/prq_ffs.sv
src/priority_ready_queue_scheduler.sv
tb/priority_ready_queue_scheduler_checker.sv
tb/priority_ready_queue_scheduler_tb.sv
